>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk_i, off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge
`define GZHS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("gzhs: assertion failed");

// expression must never be true
`define GZHS_ASSERT_NEVER(lbl, expr) \
  `GZHS_ASSERT(lbl, !(expr))

`endif

>>> hdl/gzhs_pkg.sv
// ----------------------------------------------------------------------------
// gzhs_pkg
// Types and constants of the gzip header stripper.
// ----------------------------------------------------------------------------
`default_nettype none

package gzhs_pkg;

  localparam logic [7:0] MagicFirst  = 8'h1f;
  localparam logic [7:0] MagicSecond = 8'h8b;
  localparam logic [7:0] MethodDefl  = 8'h08;
  localparam logic [7:0] FlagRsvd    = 8'he0;

  // flags byte bit positions
  localparam int unsigned FlgHcrc    = 1;
  localparam int unsigned FlgExtra   = 2;
  localparam int unsigned FlgName    = 3;
  localparam int unsigned FlgComment = 4;

  // kept flag bits
  localparam int unsigned FbHcrc    = 0;
  localparam int unsigned FbName    = 1;
  localparam int unsigned FbComment = 2;

  localparam logic [15:0] FixedSkip = 16'd6;
  localparam logic [15:0] HcrcSkip  = 16'd2;

  localparam logic [1:0] KindNone  = 2'd0;
  localparam logic [1:0] KindPlain = 2'd1;
  localparam logic [1:0] KindDefl  = 2'd2;

  localparam logic [1:0] ErrNone   = 2'd0;
  localparam logic [1:0] ErrMethod = 2'd1;
  localparam logic [1:0] ErrFlags  = 2'd2;
  localparam logic [1:0] ErrTrunc  = 2'd3;

  // result queue
  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrW  = $clog2(ResDepth);
  localparam int unsigned ResCntW  = ResPtrW + 1;

  typedef enum logic [3:0] {
    PH_MAGIC1  = 4'd0,
    PH_MAGIC2  = 4'd1,
    PH_PASS    = 4'd2,
    PH_METHOD  = 4'd3,
    PH_FLAGS   = 4'd4,
    PH_SKIPX   = 4'd5,
    PH_SKIP    = 4'd6,
    PH_XLO     = 4'd7,
    PH_XHI     = 4'd8,
    PH_XDATA   = 4'd9,
    PH_NAME    = 4'd10,
    PH_COMMENT = 4'd11,
    PH_HCRC    = 4'd12,
    PH_PAYLOAD = 4'd13,
    PH_ERRMETH = 4'd14,
    PH_ERRFLAG = 4'd15
  } phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic [1:0] err;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/gzip_header_stripper.sv
// ----------------------------------------------------------------------------
// gzip_header_stripper
// Strips a gzip member header from a byte stream and tags the bytes behind it.
// ----------------------------------------------------------------------------
// Takes one byte per cycle unless stalled. Each byte is parsed in the cycle
// it is accepted and its result words go into a four-word result queue,
// read one word per cycle from out_*_o while out_stall_i is low. A 1f not
// followed by 8b gives two words in one cycle; the input stalls whenever the
// queue has fewer than two free slots, so the sustained rate is one byte per
// cycle while the output keeps up. Header bytes give only error and end words.
`default_nettype none

module gzip_header_stripper import gzhs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      out_kind_o,
  output logic [1:0]      error_code_o,
  output logic            out_last_o
);

  phase_e              phase_q, phase_d;
  logic [2:0]          flags_q, flags_d;
  logic [15:0]         skip_q, skip_d;

  result_t             fifo_q [ResDepth];
  logic [ResPtrW-1:0]  wr_ptr_q, rd_ptr_q, wr_ptr_nx;
  logic [ResCntW-1:0]  count_q;

  logic                in_acc, pop;
  logic [1:0]          n_res;
  result_t             res0, res1;
  logic [15:0]         skip_dec;
  phase_e              ac_phase, an_phase, ae_phase;

  assign in_stall_o = (count_q > ResCntW'(ResDepth - 2));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;

  // header parser
  always_comb begin
    phase_d  = phase_q;
    flags_d  = flags_q;
    skip_d   = skip_q;
    n_res    = 2'd0;
    res0     = '0;
    res1     = '0;
    skip_dec = skip_q - 16'd1;
    ac_phase = flags_q[FbHcrc] ? PH_HCRC : PH_PAYLOAD;
    an_phase = flags_q[FbComment] ? PH_COMMENT : ac_phase;
    ae_phase = flags_q[FbName] ? PH_NAME : an_phase;

    unique case (phase_q)
      PH_MAGIC1: begin
        if (in_byte_i == MagicFirst && !in_last_i) begin
          phase_d = PH_MAGIC2;
        end else begin
          res0    = '{data: in_byte_i, kind: KindPlain, err: ErrNone, last: 1'b0};
          n_res   = 2'd1;
          phase_d = PH_PASS;
        end
      end
      PH_MAGIC2: begin
        if (in_byte_i == MagicSecond) begin
          phase_d = PH_METHOD;
        end else begin
          res0    = '{data: MagicFirst, kind: KindPlain, err: ErrNone, last: 1'b0};
          res1    = '{data: in_byte_i, kind: KindPlain, err: ErrNone, last: 1'b0};
          n_res   = 2'd2;
          phase_d = PH_PASS;
        end
      end
      PH_PASS: begin
        res0  = '{data: in_byte_i, kind: KindPlain, err: ErrNone, last: 1'b0};
        n_res = 2'd1;
      end
      PH_PAYLOAD: begin
        res0  = '{data: in_byte_i, kind: KindDefl, err: ErrNone, last: 1'b0};
        n_res = 2'd1;
      end
      PH_METHOD: begin
        if (in_byte_i != MethodDefl) begin
          phase_d = PH_ERRMETH;
          res0    = '{data: 8'h00, kind: KindNone, err: ErrMethod, last: 1'b0};
          n_res   = 2'd1;
        end else begin
          phase_d = PH_FLAGS;
        end
      end
      PH_FLAGS: begin
        if (|(in_byte_i & FlagRsvd)) begin
          phase_d = PH_ERRFLAG;
          res0    = '{data: 8'h00, kind: KindNone, err: ErrFlags, last: 1'b0};
          n_res   = 2'd1;
        end else begin
          flags_d = {in_byte_i[FlgComment], in_byte_i[FlgName], in_byte_i[FlgHcrc]};
          skip_d  = FixedSkip;
          phase_d = in_byte_i[FlgExtra] ? PH_SKIPX : PH_SKIP;
        end
      end
      PH_SKIPX, PH_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == 16'd0) begin
          phase_d = (phase_q == PH_SKIPX) ? PH_XLO : ae_phase;
        end
      end
      PH_XLO: begin
        skip_d  = {8'h00, in_byte_i};
        phase_d = PH_XHI;
      end
      PH_XHI: begin
        skip_d  = {in_byte_i, skip_q[7:0]};
        phase_d = ({in_byte_i, skip_q[7:0]} != 16'd0) ? PH_XDATA : ae_phase;
      end
      PH_XDATA: begin
        skip_d = skip_dec;
        if (skip_dec == 16'd0) begin
          phase_d = ae_phase;
        end
      end
      PH_NAME: begin
        if (in_byte_i == 8'h00) begin
          phase_d = an_phase;
        end
      end
      PH_COMMENT: begin
        if (in_byte_i == 8'h00) begin
          phase_d = ac_phase;
        end
      end
      PH_HCRC: begin
        skip_d = skip_dec;
        if (skip_dec == 16'd0) begin
          phase_d = PH_PAYLOAD;
        end
      end
      PH_ERRMETH: begin
        res0  = '{data: 8'h00, kind: KindNone, err: ErrMethod, last: 1'b0};
        n_res = 2'd1;
      end
      PH_ERRFLAG: begin
        res0  = '{data: 8'h00, kind: KindNone, err: ErrFlags, last: 1'b0};
        n_res = 2'd1;
      end
    endcase

    // entering the header CRC loads its count
    if (phase_d == PH_HCRC && phase_q != PH_HCRC) begin
      skip_d = HcrcSkip;
    end

    if (in_last_i) begin
      if (n_res == 2'd0) begin
        res0  = '{data: 8'h00, kind: KindNone,
                  err: (phase_d == PH_PAYLOAD) ? ErrNone : ErrTrunc, last: 1'b0};
        n_res = 2'd1;
      end
      if (n_res == 2'd2) begin
        res1.last = 1'b1;
      end else begin
        res0.last = 1'b1;
      end
      phase_d = PH_MAGIC1;
      flags_d = '0;
      skip_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAGIC1;
      flags_q <= '0;
      skip_q  <= '0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      flags_q <= flags_d;
      skip_q  <= skip_d;
    end
  end

  // result queue
  assign wr_ptr_nx = wr_ptr_q + ResPtrW'(1);

  always_ff @(posedge clk_i) begin
    if (in_acc && n_res != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (in_acc && n_res == 2'd2) begin
      fifo_q[wr_ptr_nx] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr_q <= wr_ptr_q + ResPtrW'(n_res);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + ResPtrW'(1);
      end
      count_q <= count_q + (in_acc ? ResCntW'(n_res) : ResCntW'(0))
                 - ResCntW'(pop);
    end
  end

  assign out_valid_o  = (count_q != '0);
  assign out_byte_o   = fifo_q[rd_ptr_q].data;
  assign out_kind_o   = fifo_q[rd_ptr_q].kind;
  assign error_code_o = fifo_q[rd_ptr_q].err;
  assign out_last_o   = fifo_q[rd_ptr_q].last;

endmodule

`default_nettype wire

>>> hdl/gzhs_checker.sv
// ----------------------------------------------------------------------------
// gzhs_checker
// Port-level checks of the gzip header stripper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gzhs_checker import gzhs_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       in_last_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] out_byte_o,
  input wire logic [1:0] out_kind_o,
  input wire logic [1:0] error_code_o,
  input wire logic       out_last_o
);

  logic        last_acc;
  logic        end_word;
  logic [12:0] out_word;

  assign last_acc = in_valid_i && !in_stall_o && in_last_i;
  assign end_word = out_valid_o && out_kind_o == KindNone &&
                    (error_code_o == ErrNone || error_code_o == ErrTrunc);
  assign out_word = {out_byte_o, out_kind_o, error_code_o, out_last_o};

  `GZHS_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_word)))
  `GZHS_ASSERT_NEVER(a_no_data_byte, out_valid_o && out_kind_o == KindNone && out_byte_o != 8'h00)
  `GZHS_ASSERT_NEVER(a_data_no_err, out_valid_o && out_kind_o != KindNone && error_code_o != ErrNone)
  `GZHS_ASSERT_NEVER(a_end_marks_last, end_word && !out_last_o)
  `GZHS_ASSERT(a_last_gives_word, last_acc |=> out_valid_o)

endmodule

bind gzip_header_stripper gzhs_checker u_gzhs_checker (.*);

`default_nettype wire

>>> tb/sv/gzhs_stream_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gzhs_stream_checker
// Predicts and checks the output words of the gzip header stripper.
// ----------------------------------------------------------------------------
// Watches both channels. Every accepted input byte runs through a header
// parser kept here, and the words it should cause are queued. Every accepted
// output word is compared field by field with the oldest queued word.
module gzhs_stream_checker import gzhs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] out_byte_i,
  input  logic [1:0] out_kind_i,
  input  logic [1:0] error_code_i,
  input  logic       out_last_i,
  output int         fail_count_o,
  output int         pending_o
);

  localparam int unsigned AfterExtra   = 0;
  localparam int unsigned AfterName    = 1;
  localparam int unsigned AfterComment = 2;

  phase_e      hdr_phase = PH_MAGIC1;
  logic [2:0]  hdr_flags = '0;
  logic [15:0] hdr_skip  = '0;
  result_t     expected_words[$];
  int          fails     = 0;
  int          pending   = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  function automatic result_t make_word(input logic [7:0] d, input logic [1:0] k,
                                        input logic [1:0] e);
    result_t w;
    w.data = d;
    w.kind = k;
    w.err  = e;
    w.last = 1'b0;
    return w;
  endfunction

  task automatic clear_header();
    hdr_phase = PH_MAGIC1;
    hdr_flags = '0;
    hdr_skip  = '0;
  endtask

  // next optional field once the given one is done
  task automatic enter_optional(input int unsigned stage);
    if (stage == AfterExtra && hdr_flags[FbName]) begin
      hdr_phase = PH_NAME;
    end else if (stage != AfterComment && hdr_flags[FbComment]) begin
      hdr_phase = PH_COMMENT;
    end else if (hdr_flags[FbHcrc]) begin
      hdr_phase = PH_HCRC;
      hdr_skip  = HcrcSkip;
    end else begin
      hdr_phase = PH_PAYLOAD;
    end
  endtask

  task automatic strip_byte(input logic [7:0] b, input logic lst);
    result_t w[$];
    result_t tail;
    case (hdr_phase)
      PH_MAGIC1: begin
        if (b == MagicFirst && !lst) begin
          hdr_phase = PH_MAGIC2;
        end else begin
          w.push_back(make_word(b, KindPlain, ErrNone));
          hdr_phase = PH_PASS;
        end
      end
      PH_MAGIC2: begin
        if (b == MagicSecond) begin
          hdr_phase = PH_METHOD;
        end else begin
          w.push_back(make_word(MagicFirst, KindPlain, ErrNone));
          w.push_back(make_word(b, KindPlain, ErrNone));
          hdr_phase = PH_PASS;
        end
      end
      PH_PASS:    w.push_back(make_word(b, KindPlain, ErrNone));
      PH_PAYLOAD: w.push_back(make_word(b, KindDefl, ErrNone));
      PH_METHOD: begin
        if (b != MethodDefl) begin
          hdr_phase = PH_ERRMETH;
          w.push_back(make_word(8'h00, KindNone, ErrMethod));
        end else begin
          hdr_phase = PH_FLAGS;
        end
      end
      PH_FLAGS: begin
        if ((b & FlagRsvd) != 8'h00) begin
          hdr_phase = PH_ERRFLAG;
          w.push_back(make_word(8'h00, KindNone, ErrFlags));
        end else begin
          hdr_flags[FbHcrc]    = b[FlgHcrc];
          hdr_flags[FbName]    = b[FlgName];
          hdr_flags[FbComment] = b[FlgComment];
          hdr_skip  = FixedSkip;
          hdr_phase = b[FlgExtra] ? PH_SKIPX : PH_SKIP;
        end
      end
      PH_SKIPX, PH_SKIP: begin
        hdr_skip = hdr_skip - 16'd1;
        if (hdr_skip == 16'd0) begin
          if (hdr_phase == PH_SKIPX) hdr_phase = PH_XLO;
          else enter_optional(AfterExtra);
        end
      end
      PH_XLO: begin
        hdr_skip  = {8'h00, b};
        hdr_phase = PH_XHI;
      end
      PH_XHI: begin
        hdr_skip = {b, hdr_skip[7:0]};
        if (hdr_skip != 16'd0) hdr_phase = PH_XDATA;
        else enter_optional(AfterExtra);
      end
      PH_XDATA: begin
        hdr_skip = hdr_skip - 16'd1;
        if (hdr_skip == 16'd0) enter_optional(AfterExtra);
      end
      PH_NAME:    if (b == 8'h00) enter_optional(AfterName);
      PH_COMMENT: if (b == 8'h00) enter_optional(AfterComment);
      PH_HCRC: begin
        hdr_skip = hdr_skip - 16'd1;
        if (hdr_skip == 16'd0) hdr_phase = PH_PAYLOAD;
      end
      PH_ERRMETH: w.push_back(make_word(8'h00, KindNone, ErrMethod));
      default:    w.push_back(make_word(8'h00, KindNone, ErrFlags));
    endcase
    if (lst) begin
      if (w.size() == 0)
        w.push_back(make_word(8'h00, KindNone,
                              (hdr_phase == PH_PAYLOAD) ? ErrNone : ErrTrunc));
      tail = w.pop_back();
      tail.last = 1'b1;
      w.push_back(tail);
      clear_header();
    end
    foreach (w[i]) expected_words.push_back(w[i]);
  endtask

  task automatic check_word(input result_t got);
    result_t exp_w;
    if (expected_words.size() == 0) begin
      $error("unexpected word: out_byte %0h out_kind %0d error_code %0d out_last %0d",
             got.data, got.kind, got.err, got.last);
      fails++;
    end else begin
      exp_w = expected_words.pop_front();
      if (got.data !== exp_w.data) begin
        $error("out_byte: expected %0h, got %0h", exp_w.data, got.data);
        fails++;
      end
      if (got.kind !== exp_w.kind) begin
        $error("out_kind: expected %0d, got %0d", exp_w.kind, got.kind);
        fails++;
      end
      if (got.err !== exp_w.err) begin
        $error("error_code: expected %0d, got %0d", exp_w.err, got.err);
        fails++;
      end
      if (got.last !== exp_w.last) begin
        $error("out_last: expected %0d, got %0d", exp_w.last, got.last);
        fails++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_header();
      expected_words.delete();
    end else begin
      if (in_valid_i && !in_stall_i) strip_byte(in_byte_i, in_last_i);
      if (out_valid_i && !out_stall_i)
        check_word({out_byte_i, out_kind_i, error_code_i, out_last_i});
    end
    pending = expected_words.size();
  end

endmodule

>>> tb/sv/tb_gzip_header_stripper.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gzip_header_stripper
// Stream-level test of the gzip header stripper.
// ----------------------------------------------------------------------------
// Sends a few directed streams (lone magic, broken magic, bad method, reserved
// flags, a full header ending on the last byte), then random streams: mostly
// well-formed gzip headers with random flags and contents, plus truncated,
// broken and plain streams. The sender works in bursts, the receiver stalls
// in changing patterns and holds off once for a long stretch. The checker
// beside the block does all the comparing.
module tb_gzip_header_stripper;
  import gzhs_pkg::*;

  localparam int unsigned ItemTarget  = 1750;
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 20;

  localparam int unsigned RxFree     = 0;
  localparam int unsigned RxCoin     = 1;
  localparam int unsigned RxHeavy    = 2;
  localparam int unsigned RxPeriodic = 3;

  typedef enum int unsigned {
    ST_GZIP, ST_TRUNC, ST_BAD_METHOD, ST_BAD_FLAGS, ST_NO_MAGIC, ST_LONE_MAGIC, ST_NOISE
  } stream_e;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] in_byte_i;
  logic       in_last_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_byte_o;
  logic [1:0] out_kind_o;
  logic [1:0] error_code_o;
  logic       out_last_o;

  int          fail_count;
  int          pending;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  int unsigned bytes_sent  = 0;
  logic [7:0]  stream_q[$];

  always #5 clk_i = ~clk_i;

  gzip_header_stripper uut (.*);

  gzhs_stream_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_i   (out_byte_o),
    .out_kind_i   (out_kind_o),
    .error_code_i (error_code_o),
    .out_last_i   (out_last_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count == CycleLimit);
    $display("FAILURE");
    $finish;
  end

  task automatic push_random(input int unsigned n);
    repeat (n) stream_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic push_zstring();
    repeat ($urandom_range(0, 4)) stream_q.push_back(8'($urandom_range(1, 255)));
    stream_q.push_back(8'h00);
  endtask

  task automatic build_gzip();
    logic [7:0]  flg;
    logic [15:0] xlen;
    flg = 8'($urandom_range(0, 31));
    stream_q.push_back(MagicFirst);
    stream_q.push_back(MagicSecond);
    stream_q.push_back(MethodDefl);
    stream_q.push_back(flg);
    push_random(6);
    if (flg[FlgExtra]) begin
      xlen = ($urandom_range(0, 39) == 0) ? 16'($urandom_range(256, 400))
                                          : 16'($urandom_range(0, 6));
      stream_q.push_back(xlen[7:0]);
      stream_q.push_back(xlen[15:8]);
      push_random(xlen);
    end
    if (flg[FlgName]) push_zstring();
    if (flg[FlgComment]) push_zstring();
    if (flg[FlgHcrc]) push_random(2);
    push_random($urandom_range(0, 8));
  endtask

  task automatic build_stream(input stream_e kind);
    logic [7:0]  b;
    int unsigned keep;
    stream_q.delete();
    case (kind)
      ST_GZIP: build_gzip();
      ST_TRUNC: begin
        build_gzip();
        keep = $urandom_range(1, stream_q.size() - 1);
        while (stream_q.size() > keep) void'(stream_q.pop_back());
      end
      ST_BAD_METHOD: begin
        b = 8'($urandom_range(0, 255));
        if (b == MethodDefl) b = 8'hff;
        stream_q = '{MagicFirst, MagicSecond, b};
        push_random($urandom_range(0, 4));
      end
      ST_BAD_FLAGS: begin
        b = 8'($urandom_range(0, 255));
        b[$urandom_range(5, 7)] = 1'b1;
        stream_q = '{MagicFirst, MagicSecond, MethodDefl, b};
        push_random($urandom_range(0, 4));
      end
      ST_NO_MAGIC: begin
        b = 8'($urandom_range(0, 255));
        if (b == MagicFirst) b = 8'h00;
        stream_q.push_back(b);
        push_random($urandom_range(0, 8));
      end
      ST_LONE_MAGIC: begin
        stream_q.push_back(MagicFirst);
        if ($urandom_range(0, 3) != 0) begin
          b = 8'($urandom_range(0, 255));
          if (b == MagicSecond) b = 8'h00;
          stream_q.push_back(b);
          push_random($urandom_range(0, 4));
        end
      end
      default: push_random($urandom_range(1, 10));
    endcase
  endtask

  task automatic send_word(input logic [7:0] b, input logic lst);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 6);
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_stream();
    foreach (stream_q[i]) send_word(stream_q[i], i == stream_q.size() - 1);
  endtask

  // receiver stall pattern, with one long hold-off to back up the block
  initial begin
    int unsigned mode;
    int unsigned run;
    int unsigned round;
    int unsigned tick;
    out_stall_i = 1'b0;
    round = 0;
    tick  = 0;
    wait (rst_ni);
    forever begin
      round++;
      if (round == 4) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        mode = $urandom_range(RxFree, RxPeriodic);
        run  = $urandom_range(20, 200);
        repeat (run) begin
          @(negedge clk_i);
          tick++;
          case (mode)
            RxFree:  out_stall_i <= 1'b0;
            RxCoin:  out_stall_i <= 1'($urandom_range(0, 1));
            RxHeavy: out_stall_i <= ($urandom_range(0, 9) < 8);
            default: out_stall_i <= ((tick % 5) < 2);
          endcase
        end
      end
    end
  end

  initial begin
    int unsigned pick;
    stream_e     kind;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_byte_i  = 8'h00;
    in_last_i  = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed streams
    stream_q = '{MagicFirst};
    send_stream();
    stream_q = '{MagicFirst, 8'h00};
    send_stream();
    stream_q = '{MagicFirst, MagicSecond, 8'h07, 8'hff};
    send_stream();
    stream_q = '{MagicFirst, MagicSecond, MethodDefl, 8'he0, 8'hff};
    send_stream();
    // extra field of zero length, header CRC, header ends on the last byte
    stream_q = '{MagicFirst, MagicSecond, MethodDefl, 8'h1e, 8'hff, 8'h00, 8'h55,
                 8'haa, 8'h01, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'h00};
    send_stream();

    while (bytes_sent < ItemTarget) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) kind = ST_GZIP;
      else if (pick < 65) kind = ST_TRUNC;
      else if (pick < 72) kind = ST_BAD_METHOD;
      else if (pick < 79) kind = ST_BAD_FLAGS;
      else if (pick < 87) kind = ST_NO_MAGIC;
      else if (pick < 93) kind = ST_LONE_MAGIC;
      else kind = ST_NOISE;
      build_stream(kind);
      send_stream();
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/gzhs_pkg.sv
hdl/gzip_header_stripper.sv
hdl/gzhs_checker.sv
tb/sv/gzhs_stream_checker.sv
tb/sv/tb_gzip_header_stripper.sv
